[sv/gdq_pkg.sv]
// shared types, constants and calendar helper functions for the date query block
package gdq_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int WD_W    = 3;
  localparam int FEST_W  = 4;
  localparam int DIFF_W  = 23;
  localparam int YD_W    = 23;
  localparam int DN_W    = 24;
  localparam int CUM_W   = 9;
  localparam int Q_W     = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_YEAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_MONTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_DAY   = 2'd2;

  localparam logic [YEAR_W-1:0]  YEAR_MIN      = 14'd1582;
  localparam logic [YEAR_W-1:0]  YEAR_MAX      = 14'd9999;
  localparam logic [YEAR_W-1:0]  REF_YEAR_RST  = 14'd2000;
  localparam logic [MONTH_W-1:0] REF_MONTH_RST = 4'd1;
  localparam logic [DAY_W-1:0]   REF_DAY_RST   = 5'd1;

  localparam int DIFF_LIMIT    = 3100000;
  localparam int CENTURY       = 100;
  localparam int DAYS_PER_YEAR = 365;

  // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
  localparam int RECIP_W     = 13;
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;

  localparam int NUM_FESTIVALS = 14;
  localparam int FEST_SLOTS    = 32;

  localparam logic [MONTH_W-1:0] FEST_MONTH [FEST_SLOTS] = '{
    0: 4'd1, 1: 4'd2, 2: 4'd3, 3: 4'd3, 4: 4'd4, 5: 4'd5, 6: 4'd5,
    7: 4'd6, 8: 4'd7, 9: 4'd8, 10: 4'd9, 11: 4'd10, 12: 4'd12, 13: 4'd12,
    default: 4'd0
  };
  localparam logic [DAY_W-1:0] FEST_DAY [FEST_SLOTS] = '{
    0: 5'd1, 1: 5'd14, 2: 5'd8, 3: 5'd12, 4: 5'd1, 5: 5'd1, 6: 5'd4,
    7: 5'd1, 8: 5'd1, 9: 5'd1, 10: 5'd10, 11: 5'd1, 12: 5'd24, 13: 5'd25,
    default: 5'd0
  };

  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } stage_en_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = '0;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days of the whole months before m; months past twelve count the full year
  function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m,
                                                input logic leap);
    logic [CUM_W-1:0] cum;
    cum = '0;
    case (m) inside
      4'd0, 4'd1: cum = 9'd0;
      4'd2:       cum = 9'd31;
      4'd3:       cum = 9'd59;
      4'd4:       cum = 9'd90;
      4'd5:       cum = 9'd120;
      4'd6:       cum = 9'd151;
      4'd7:       cum = 9'd181;
      4'd8:       cum = 9'd212;
      4'd9:       cum = 9'd243;
      4'd10:      cum = 9'd273;
      4'd11:      cum = 9'd304;
      4'd12:      cum = 9'd334;
      default:    cum = 9'd365;
    endcase
    if (leap && (m >= 4'd3)) begin
      cum = cum + 9'd1;
    end
    return cum;
  endfunction

  function automatic logic signed [DN_W-1:0] day_number(input logic [YD_W-1:0] yd,
                                                        input logic [CUM_W-1:0] cum,
                                                        input logic [DAY_W-1:0] d);
    logic [DN_W-1:0] n;
    n = DN_W'(yd) + DN_W'(cum) + DN_W'(d) - DN_W'(1);
    return $signed(n);
  endfunction

  // first matching festival by table order, 0 if none
  function automatic logic [FEST_W-1:0] festival_of(input logic [MONTH_W-1:0] m,
                                                    input logic [DAY_W-1:0] d);
    logic [FEST_W-1:0] idx;
    idx = '0;
    for (int i = NUM_FESTIVALS - 1; i >= 0; i--) begin
      if (i < FEST_SLOTS) begin
        if ((FEST_MONTH[i] == m) && (FEST_DAY[i] == d)) begin
          idx = FEST_W'(i + 1);
        end
      end
    end
    return idx;
  endfunction

  // x mod 7 by folding octal digits, since 8 is 1 mod 7
  function automatic logic [WD_W-1:0] mod7(input logic [DN_W-1:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = '0;
    for (int i = 0; i < DN_W / 3; i++) begin
      s1 = s1 + 6'(x[3*i +: 3]);
    end
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = 4'(s2[3]) + 4'(s2[2:0]);
    if (s3 >= 4'd7) begin
      s3 = s3 - 4'd7;
    end
    return s3[WD_W-1:0];
  endfunction

endpackage

[sv/gregorian_date_query.sv]
// top level of the Gregorian date query pipeline
// Takes one date per cycle while the output side is not stalling and returns one result
// per date; a stall holds every stage full without loss. The six register stages are:
// input register, century quotient, leap rule, whole-year day count, month/day check
// with the day number, and the output register with weekday and the saturated
// difference to the reference date. The reference day number is rebuilt from the
// configuration registers by a second year pipeline and a register behind it, and is
// settled before any item accepted after a write reaches the stage that uses it.
// cfg_ready is always high.
module gregorian_date_query import gdq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [YEAR_W-1:0]        in_query_year,
  input  logic [MONTH_W-1:0]       in_query_month,
  input  logic [DAY_W-1:0]         in_query_day,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_date_valid,
  output logic [WD_W-1:0]          out_weekday,
  output logic [DAY_W-1:0]         out_month_length,
  output logic signed [DIFF_W-1:0] out_days_from_reference,
  output logic [FEST_W-1:0]        out_festival_index,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  // configuration
  logic [YEAR_W-1:0]  ref_year_r;
  logic [MONTH_W-1:0] ref_month_r;
  logic [DAY_W-1:0]   ref_day_r;

  // stage valid bits and load enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  // item payload carried beside the year pipeline
  logic [YEAR_W-1:0]  y1_r;
  logic [MONTH_W-1:0] m1_r, m2_r, m3_r, m4_r;
  logic [DAY_W-1:0]   d1_r, d2_r, d3_r, d4_r;
  logic               yok2_r, yok3_r, yok4_r;
  logic               yok2_nxt;

  stage_en_t         item_en;
  stage_en_t         ref_en;
  logic              leap4;
  logic [YD_W-1:0]   yd4;
  logic              ref_leap;
  logic [YD_W-1:0]   ref_yd;

  logic [DAY_W-1:0]        len4;
  logic [CUM_W-1:0]        cum4;
  logic                    ok4;
  logic signed [DN_W-1:0]  n4;
  logic [FEST_W-1:0]       fest4;

  logic                    ok5_r;
  logic [DAY_W-1:0]        len5_r;
  logic [FEST_W-1:0]       fest5_r;
  logic signed [DN_W-1:0]  n5_r;

  logic signed [DN_W-1:0]  refn_r, refn_nxt;

  logic signed [DN_W-1:0]   diff5;
  logic signed [DIFF_W-1:0] diff_sat;
  logic [DN_W-1:0]          n5_plus1;
  logic [WD_W-1:0]          wd_nxt;

  logic                     ok6_r;
  logic [WD_W-1:0]          wd6_r;
  logic [DAY_W-1:0]         len6_r;
  logic signed [DIFF_W-1:0] diff6_r;
  logic [FEST_W-1:0]        fest6_r;

  // a stage loads when it is empty or its content moves on
  assign rdy6     = !v6_r || out_ready;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_year_r  <= REF_YEAR_RST;
      ref_month_r <= REF_MONTH_RST;
      ref_day_r   <= REF_DAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REF_YEAR:  ref_year_r  <= cfg_data[YEAR_W-1:0];
        CFG_REF_MONTH: ref_month_r <= cfg_data[MONTH_W-1:0];
        CFG_REF_DAY:   ref_day_r   <= cfg_data[DAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  assign yok2_nxt = (y1_r >= YEAR_MIN) && (y1_r <= YEAR_MAX);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      y1_r <= in_query_year;
      m1_r <= in_query_month;
      d1_r <= in_query_day;
    end
    if (rdy2) begin
      m2_r   <= m1_r;
      d2_r   <= d1_r;
      yok2_r <= yok2_nxt;
    end
    if (rdy3) begin
      m3_r   <= m2_r;
      d3_r   <= d2_r;
      yok3_r <= yok2_r;
    end
    if (rdy4) begin
      m4_r   <= m3_r;
      d4_r   <= d3_r;
      yok4_r <= yok3_r;
    end
  end

  assign item_en = '{a: rdy2, b: rdy3, c: rdy4};
  assign ref_en  = '{a: 1'b1, b: 1'b1, c: 1'b1};

  gdq_year_calc u_item_year (
    .clk       (clk),
    .en        (item_en),
    .year      (y1_r),
    .leap      (leap4),
    .year_days (yd4)
  );

  // the reference path runs freely off the configuration registers
  gdq_year_calc u_ref_year (
    .clk       (clk),
    .en        (ref_en),
    .year      (ref_year_r),
    .leap      (ref_leap),
    .year_days (ref_yd)
  );

  assign refn_nxt = day_number(ref_yd, cum_days(ref_month_r, ref_leap), ref_day_r);

  always_ff @(posedge clk) begin
    refn_r <= refn_nxt;
  end

  // stage 5: month length, date check, festival and day number
  always_comb begin
    len4  = month_len(m4_r, leap4);
    cum4  = cum_days(m4_r, leap4);
    ok4   = yok4_r && (len4 != '0) && (d4_r != '0) && (d4_r <= len4);
    n4    = day_number(yd4, cum4, d4_r);
    fest4 = ok4 ? festival_of(m4_r, d4_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      ok5_r   <= ok4;
      len5_r  <= len4;
      fest5_r <= fest4;
      n5_r    <= n4;
    end
  end

  // stage 6: weekday from the day number, day 0 of year 1 being a Monday, and the saturated difference to the reference
  always_comb begin
    n5_plus1 = $unsigned(n5_r) + DN_W'(1);
    wd_nxt   = ok5_r ? mod7(n5_plus1) : '0;
    diff5    = n5_r - refn_r;
    if (!ok5_r) begin
      diff_sat = '0;
    end else if (diff5 > DN_W'(DIFF_LIMIT)) begin
      diff_sat = DIFF_W'(DIFF_LIMIT);
    end else if (diff5 < -DN_W'(DIFF_LIMIT)) begin
      diff_sat = -DIFF_W'(DIFF_LIMIT);
    end else begin
      diff_sat = diff5[DIFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      ok6_r   <= ok5_r;
      wd6_r   <= wd_nxt;
      len6_r  <= len5_r;
      diff6_r <= diff_sat;
      fest6_r <= fest5_r;
    end
  end

  assign out_valid               = v6_r;
  assign out_date_valid          = ok6_r;
  assign out_weekday             = wd6_r;
  assign out_month_length        = len6_r;
  assign out_days_from_reference = diff6_r;
  assign out_festival_index      = fest6_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_date_valid |->
      (out_weekday == '0) && (out_days_from_reference == '0) && (out_festival_index == '0))
    else $error("invalid date result carries nonzero fields");

  a_valid_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_date_valid |-> (out_month_length >= 5'd28) && (out_weekday <= 3'd6))
    else $error("valid date with bad month length or weekday");

  a_diff_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_days_from_reference <= DIFF_LIMIT) &&
                  (out_days_from_reference >= -DIFF_LIMIT))
    else $error("day difference outside saturation range");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r && v2_r && v3_r && v4_r && v5_r && v6_r && !out_ready)
    else $error("input stalled while the pipeline has room");

  a_stage5_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !rdy5 |=> v5_r && (n5_r == $past(n5_r)) && (ok5_r == $past(ok5_r)))
    else $error("stalled item changed in stage 5");

endmodule

[sv/gdq_year_calc.sv]
// three-stage pipeline giving the leap flag and the days of all whole years before a year
module gdq_year_calc import gdq_pkg::*; (
  input  logic              clk,
  input  stage_en_t         en,
  input  logic [YEAR_W-1:0] year,
  output logic              leap,
  output logic [YD_W-1:0]   year_days
);

  localparam int PROD_W = YEAR_W + RECIP_W;

  logic [YEAR_W-1:0] year_a_r;
  logic [Q_W-1:0]    q_a_r;
  logic [Q_W-1:0]    q_a_nxt;
  logic [PROD_W-1:0] prod;

  logic              leap_b_r, leap_b_nxt;
  logic [YEAR_W-1:0] yb_b_r, yb_b_nxt;
  logic [Q_W-1:0]    yb100_b_r, yb100_b_nxt;
  logic [YEAR_W-1:0] hund;
  logic [YEAR_W-1:0] rem;
  logic              rem_zero;
  logic              year_zero;

  logic              leap_c_r;
  logic [YD_W-1:0]   yd_c_r, yd_c_nxt;

  // stage a: century count by reciprocal multiply
  always_comb begin
    prod    = PROD_W'(year) * PROD_W'(RECIP_100);
    q_a_nxt = Q_W'(prod >> RECIP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en.a) begin
      year_a_r <= year;
      q_a_r    <= q_a_nxt;
    end
  end

  // stage b: leap rule and the quotients of the year before
  always_comb begin
    hund        = YEAR_W'(q_a_r) * YEAR_W'(CENTURY);
    rem         = year_a_r - hund;
    rem_zero    = (rem == '0);
    year_zero   = (year_a_r == '0);
    leap_b_nxt  = ((year_a_r[1:0] == 2'b00) && !rem_zero) ||
                  (rem_zero && (q_a_r[1:0] == 2'b00));
    yb_b_nxt    = year_zero ? '0 : year_a_r - YEAR_W'(1);
    yb100_b_nxt = year_zero ? '0 : (rem_zero ? q_a_r - Q_W'(1) : q_a_r);
  end

  always_ff @(posedge clk) begin
    if (en.b) begin
      leap_b_r  <= leap_b_nxt;
      yb_b_r    <= yb_b_nxt;
      yb100_b_r <= yb100_b_nxt;
    end
  end

  // stage c: 365 per year plus the leap days
  always_comb begin
    yd_c_nxt = YD_W'(yb_b_r) * YD_W'(DAYS_PER_YEAR) + YD_W'(yb_b_r >> 2)
             - YD_W'(yb100_b_r) + YD_W'(yb100_b_r >> 2);
  end

  always_ff @(posedge clk) begin
    if (en.c) begin
      leap_c_r <= leap_b_r;
      yd_c_r   <= yd_c_nxt;
    end
  end

  assign leap      = leap_c_r;
  assign year_days = yd_c_r;

endmodule

[tb/sv/testbench.sv]
// testbench for the Gregorian date query block: directed corner dates, then random dates
`timescale 1ns / 1ps

module testbench;
  import gdq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int DIFF_CAP = 3100000;

  typedef struct {
    int         y;
    int         m;
    int         d;
    bit         ok;
    bit [2:0]   wday;
    bit [4:0]   mlen;
    bit [22:0]  delta;
    bit [3:0]   fest;
  } date_answer_t;

  class date_scoreboard;
    date_answer_t pending[$];
    int ref_y = 2000;
    int ref_m = 1;
    int ref_d = 1;
    int fails = 0;
    int holiday_month[14] = '{1, 2, 3, 3, 4, 5, 5, 6, 7, 8, 9, 10, 12, 12};
    int holiday_day[14]   = '{1, 14, 8, 12, 1, 1, 4, 1, 1, 1, 10, 1, 24, 25};

    task report(string msg);
      fails++;
      $display("%0t: error: %s", $time, msg);
    endtask

    function bit is_leap(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int days_in_month(int y, int m);
      case (m)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        2:                     return is_leap(y) ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    // days since the start of year 1, with no range checks on the date
    function int serial_day(int y, int m, int d);
      int yb;
      int n;
      yb = (y > 0) ? y - 1 : 0;
      n = yb * 365 + yb / 4 - yb / 100 + yb / 400;
      for (int k = 1; k < m && k <= 12; k++) begin
        n += days_in_month(y, k);
      end
      return n + d - 1;
    endfunction

    // zeller congruence, shifted so that 0 is sunday
    function int zeller(int y, int m, int d);
      int k;
      int j;
      int h;
      if (m < 3) begin
        m += 12;
        y -= 1;
      end
      k = y % 100;
      j = y / 100;
      h = (d + 13 * (m + 1) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
      return (h + 6) % 7;
    endfunction

    function date_answer_t answer_for(int y, int m, int d);
      date_answer_t a;
      int len;
      int diff;
      len = days_in_month(y, m);
      a.y = y;
      a.m = m;
      a.d = d;
      a.ok = (y >= 1582) && (y <= 9999) && (len != 0) && (d >= 1) && (d <= len);
      a.mlen = 5'(len);
      a.wday = '0;
      a.delta = '0;
      a.fest = '0;
      if (a.ok) begin
        a.wday = 3'(zeller(y, m, d));
        diff = serial_day(y, m, d) - serial_day(ref_y, ref_m, ref_d);
        if (diff > DIFF_CAP) diff = DIFF_CAP;
        if (diff < -DIFF_CAP) diff = -DIFF_CAP;
        a.delta = 23'(diff);
        for (int i = 0; i < 14; i++) begin
          if (a.fest == 0 && holiday_month[i] == m && holiday_day[i] == d) begin
            a.fest = 4'(i + 1);
          end
        end
      end
      return a;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_REF_YEAR:  ref_y = int'(val);
        CFG_REF_MONTH: ref_m = int'(val[3:0]);
        CFG_REF_DAY:   ref_d = int'(val[4:0]);
        default: ;
      endcase
    endfunction

    function void note_query(logic [13:0] y, logic [3:0] m, logic [4:0] d);
      pending.push_back(answer_for(int'(y), int'(m), int'(d)));
    endfunction

    task check_result(logic ok, logic [2:0] wday, logic [4:0] mlen, logic [22:0] delta,
                      logic [3:0] fest);
      date_answer_t want;
      string tag;
      if (pending.size() == 0) begin
        report("result arrived with no query outstanding");
        return;
      end
      want = pending.pop_front();
      tag = $sformatf("%0d-%0d-%0d", want.y, want.m, want.d);
      if (ok !== want.ok)
        report($sformatf("%s date_valid got %b want %b", tag, ok, want.ok));
      if (wday !== want.wday)
        report($sformatf("%s weekday got %0d want %0d", tag, wday, want.wday));
      if (mlen !== want.mlen)
        report($sformatf("%s month_length got %0d want %0d", tag, mlen, want.mlen));
      if (delta !== want.delta)
        report($sformatf("%s days_from_reference got %0d want %0d", tag,
                         $signed(delta), $signed(want.delta)));
      if (fest !== want.fest)
        report($sformatf("%s festival_index got %0d want %0d", tag, fest, want.fest));
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [YEAR_W-1:0]        in_query_year = '0;
  logic [MONTH_W-1:0]       in_query_month = '0;
  logic [DAY_W-1:0]         in_query_day = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_date_valid;
  logic [WD_W-1:0]          out_weekday;
  logic [DAY_W-1:0]         out_month_length;
  logic signed [DIFF_W-1:0] out_days_from_reference;
  logic [FEST_W-1:0]        out_festival_index;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  bit steady = 1'b0;
  date_scoreboard sb;

  // year, month, day packed as one word
  logic [22:0] corners [24] = '{
    {14'd1582, 4'd1, 5'd1},   {14'd9999, 4'd12, 5'd31}, {14'd1581, 4'd12, 5'd31},
    {14'd10000, 4'd1, 5'd1},  {14'd0, 4'd0, 5'd0},      {14'd16383, 4'd15, 5'd31},
    {14'd2000, 4'd2, 5'd29},  {14'd1900, 4'd2, 5'd29},  {14'd2024, 4'd2, 5'd29},
    {14'd2023, 4'd2, 5'd29},  {14'd2023, 4'd4, 5'd31},  {14'd2023, 4'd4, 5'd30},
    {14'd2023, 4'd13, 5'd1},  {14'd2023, 4'd6, 5'd0},   {14'd2000, 4'd1, 5'd1},
    {14'd2023, 4'd12, 5'd25}, {14'd2023, 4'd1, 5'd1},   {14'd2023, 4'd12, 5'd24},
    {14'd2023, 4'd3, 5'd12},  {14'd1582, 4'd10, 5'd15}, {14'd2000, 4'd3, 5'd1},
    {14'd9999, 4'd2, 5'd28},  {14'd2023, 4'd1, 5'd31},  {14'd1600, 4'd2, 5'd29}
  };

  gregorian_date_query DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_query_year           (in_query_year),
    .in_query_month          (in_query_month),
    .in_query_day            (in_query_day),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_date_valid          (out_date_valid),
    .out_weekday             (out_weekday),
    .out_month_length        (out_month_length),
    .out_days_from_reference (out_days_from_reference),
    .out_festival_index      (out_festival_index),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 33);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_date_valid, out_weekday, out_month_length,
                      out_days_from_reference, out_festival_index);
    end
  end

  function bit take_break();
    return !steady && ($urandom_range(99) < 33);
  endfunction

  task send_date(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_query_year <= y;
    in_query_month <= m;
    in_query_day <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_query(y, m, d);
  endtask

  // leaves cfg_valid high so back-to-back writes need no extra step
  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.configure(idx, val);
  endtask

  task set_reference(input int y, input int m, input int d);
    write_reg(CFG_REF_YEAR, 14'(y));
    write_reg(CFG_REF_MONTH, 14'(m));
    write_reg(CFG_REF_DAY, 14'(d));
    cfg_valid <= 1'b0;
  endtask

  task settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task pick_date(output logic [13:0] y, output logic [3:0] m, output logic [4:0] d);
    int roll;
    int k;
    roll = $urandom_range(99);
    y = 14'($urandom_range(9999, 1582));
    m = 4'($urandom_range(12, 1));
    d = 5'($urandom_range(sb.days_in_month(y, m), 1));
    if (roll < 70) begin
      // plain well-formed date
    end else if (roll < 78) begin
      k = $urandom_range(13);
      m = 4'(sb.holiday_month[k]);
      d = 5'(sb.holiday_day[k]);
    end else if (roll < 85) begin
      // years around both ends of the range, day possibly past month end
      k = $urandom_range(5);
      y = 14'((k < 3) ? 1581 + k : 9995 + k);
      d = 5'($urandom_range(31, 1));
    end else if (roll < 90) begin
      m = 4'd2;
      d = 5'd29;
    end else begin
      y = 14'($urandom);
      m = 4'($urandom);
      d = 5'($urandom);
    end
  endtask

  task run_batch(input int count);
    logic [13:0] y;
    logic [3:0] m;
    logic [4:0] d;
    repeat (count) begin
      pick_date(y, m, d);
      send_date(y, m, d);
    end
  endtask

  initial begin
    int ry;
    int rm;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corners[i]) begin
      send_date(corners[i][22:9], corners[i][8:5], corners[i][4:0]);
    end
    run_batch(216);

    settle();
    set_reference(1582, 1, 1);
    steady = 1'b1;
    run_batch(240);
    steady = 1'b0;

    settle();
    set_reference(9999, 12, 31);
    run_batch(240);

    // malformed references exercise the unchecked day number and saturation
    settle();
    set_reference(0, 0, 0);
    run_batch(240);

    settle();
    set_reference(16383, 15, 31);
    run_batch(240);

    settle();
    ry = $urandom_range(9999, 1582);
    rm = $urandom_range(12, 1);
    set_reference(ry, rm, $urandom_range(sb.days_in_month(ry, rm), 1));
    run_batch(240);

    settle();
    write_reg(CFG_SPARE, 14'($urandom));
    set_reference($urandom_range(16383), $urandom_range(15), $urandom_range(31));
    run_batch(240);

    settle();
    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
